### sv/bpc_pkg.sv
// Shared types and constants for the block permutation cipher.
package bpc_pkg;

  localparam int BL_W  = 5;
  localparam int KEY_W = 4;
  localparam int KEY_N = 16;
  localparam int KM_W  = KEY_W * KEY_N;
  localparam int CFG_W = KM_W;
  localparam int CIDX_W = 2;

  localparam logic [CIDX_W-1:0] CFG_BLOCK_LENGTH  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_KEY_MAP       = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_DECIPHER_MODE = 2'd2;

  localparam logic [BL_W-1:0] BLOCK_LENGTH_RST = 5'd16;
  localparam logic [KM_W-1:0] KEY_MAP_RST      = 64'hFEDC_BA98_7654_3210;

  localparam logic [7:0] CHAR_BELOW_PRINT = 8'd31;
  localparam logic [7:0] CHAR_ABOVE_PRINT = 8'd127;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       flush;
    logic [6:0] fill_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  function automatic logic is_printable(input logic [7:0] b);
    return (b > CHAR_BELOW_PRINT) && (b < CHAR_ABOVE_PRINT);
  endfunction

endpackage

### sv/bpc_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
interface bpc_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### sv/bpc_src_sel.sv
// Source position select for one output slot, forward or inverse key.
module bpc_src_sel #(
  parameter int MAX_BLOCK = 16
) (
  input  logic [$clog2(MAX_BLOCK)-1:0]   idx,
  input  logic [$clog2(MAX_BLOCK+1)-1:0] len,
  input  logic [bpc_pkg::KM_W-1:0]       key_map,
  input  logic                           decipher,
  output logic [$clog2(MAX_BLOCK)-1:0]   src
);
  import bpc_pkg::*;

  localparam int AW = $clog2(MAX_BLOCK);
  localparam int LW = $clog2(MAX_BLOCK+1);

  logic [KEY_W-1:0] fwd_key;
  logic [AW-1:0]    fwd_src;
  logic [AW-1:0]    inv_src;
  logic [KEY_W-1:0] idx_k;

  assign idx_k   = KEY_W'(idx);
  assign fwd_key = key_map[KEY_W*idx_k +: KEY_W];

  always_comb begin
    if (LW'(fwd_key) >= len || fwd_key > KEY_W'(MAX_BLOCK - 1)) begin
      fwd_src = '0;
    end else begin
      fwd_src = AW'(fwd_key);
    end
  end

  // Scan from the top so the lowest matching position wins.
  always_comb begin
    inv_src = '0;
    for (int j = MAX_BLOCK - 1; j >= 0; j--) begin
      if (LW'(j) < len && key_map[KEY_W*j +: KEY_W] == idx_k) begin
        inv_src = AW'(j);
      end
    end
  end

  assign src = decipher ? inv_src : fwd_src;

endmodule

### sv/block_permutation_cipher.sv
// Top level of the block permutation cipher: buffer memory, sequencer and output register.
//
//  channel | direction | handshake      | payload
//  in_ch   | in        | valid / ready  | data_byte[7:0], flush, fill_char[6:0]
//  out_ch  | out       | valid / ready  | out_byte[7:0], last
//  cfg     | in        | cfg_we         | cfg_index[1:0], cfg_wdata[63:0]
//
// A pass-through byte goes straight to the output register and a buffered byte to the
// buffer; a block is emitted byte by byte, one buffer read (ST_RD) then one output register load (ST_WR) per byte.
// The single-port buffer read and the output register set the block rate.
// Reset is synchronous; the buffer holds no reset and needs no clearing.
// A stalled output holds the sequencer; input is taken only when idle.
module block_permutation_cipher #(
  parameter int MAX_BLOCK = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bpc_stream_if.sink                     in_ch,
  bpc_stream_if.source                   out_ch,
  input  logic                           cfg_we,
  input  logic [bpc_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [bpc_pkg::CFG_W-1:0]      cfg_wdata
);
  import bpc_pkg::*;

  localparam int AW = $clog2(MAX_BLOCK);
  localparam int LW = $clog2(MAX_BLOCK+1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_WR   = 2'd2;

  logic [7:0] buf_mem [MAX_BLOCK];
  logic [7:0] mem_q_r;

  logic [1:0]      state_r, state_nxt;
  logic [LW-1:0]   fill_count_r, fill_count_nxt;
  logic [LW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [6:0]      fill_r, fill_nxt;
  logic            pad_r, pad_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;

  logic [BL_W-1:0] block_length_r;
  logic [KM_W-1:0] key_map_r;
  logic            decipher_r;

  logic [LW-1:0]   len;
  logic [LW-1:0]   pos;
  logic [LW-1:0]   pos_inc;
  logic [AW-1:0]   src;
  logic            out_free;
  logic            in_fire;
  logic            mem_we;
  logic            mem_re;
  in_item_t        in_item;

  assign in_item  = in_ch.payload;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign in_fire  = in_ch.valid && in_ch.ready;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

  always_comb begin
    if (block_length_r == '0) begin
      len = LW'(1);
    end else if (block_length_r > BL_W'(MAX_BLOCK)) begin
      len = LW'(MAX_BLOCK);
    end else begin
      len = LW'(block_length_r);
    end
  end

  assign pos     = (fill_count_r >= len) ? len - LW'(1) : fill_count_r;
  assign pos_inc = pos + LW'(1);

  bpc_src_sel #(.MAX_BLOCK(MAX_BLOCK)) u_src_sel (
    .idx      (idx_r),
    .len      (len),
    .key_map  (key_map_r),
    .decipher (decipher_r),
    .src      (src)
  );

  assign mem_we = in_fire && !in_item.flush && is_printable(in_item.data_byte);
  assign mem_re = (state_r == ST_RD);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      buf_mem[pos[AW-1:0]] <= in_item.data_byte;
    end
    if (mem_re) begin
      mem_q_r <= buf_mem[src];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    fill_count_nxt = fill_count_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    fill_nxt       = fill_r;
    pad_nxt        = pad_r;
    out_item_nxt   = out_item_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_item.flush) begin
            if (fill_count_r != '0) begin
              cnt_nxt        = fill_count_r;
              fill_nxt       = in_item.fill_char;
              fill_count_nxt = '0;
              idx_nxt        = '0;
              state_nxt      = ST_RD;
            end
          end else if (is_printable(in_item.data_byte)) begin
            if (pos_inc >= len) begin
              cnt_nxt        = pos_inc;
              fill_count_nxt = '0;
              idx_nxt        = '0;
              state_nxt      = ST_RD;
            end else begin
              fill_count_nxt = pos_inc;
            end
          end else begin
            out_item_nxt.out_byte = in_item.data_byte;
            out_item_nxt.last     = 1'b1;
            out_valid_nxt         = 1'b1;
          end
        end
      end
      ST_RD: begin
        pad_nxt   = (LW'(src) >= cnt_r);
        state_nxt = ST_WR;
      end
      ST_WR: begin
        if (out_free) begin
          out_item_nxt.out_byte = pad_r ? {1'b0, fill_r} : mem_q_r;
          out_item_nxt.last     = (LW'(idx_r) == len - LW'(1));
          out_valid_nxt         = 1'b1;
          if (LW'(idx_r) == len - LW'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      fill_count_r   <= '0;
      out_valid_r    <= 1'b0;
      block_length_r <= BLOCK_LENGTH_RST;
      key_map_r      <= KEY_MAP_RST;
      decipher_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_count_r <= fill_count_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BLOCK_LENGTH:  block_length_r <= cfg_wdata[BL_W-1:0];
          CFG_KEY_MAP:       key_map_r      <= cfg_wdata[KM_W-1:0];
          CFG_DECIPHER_MODE: decipher_r     <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    fill_r     <= fill_nxt;
    pad_r      <= pad_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

### sv/bpc_checker.sv
// Port-level checks for the block permutation cipher, bound to the top level.
module bpc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_data_byte,
  input logic       in_flush,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);
  import bpc_pkg::*;

  logic in_xfer;
  logic out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !in_flush && !is_printable(in_data_byte)
    |=> out_valid && out_last && out_byte == $past(in_data_byte))
    else $error("non-printable byte not passed through");

  a_block_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !out_last |-> !in_ready)
    else $error("input taken in the middle of a block");

endmodule

bind block_permutation_cipher bpc_checker u_bpc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_data_byte (in_ch.payload.data_byte),
  .in_flush     (in_ch.payload.flush),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_byte     (out_ch.payload.out_byte),
  .out_last     (out_ch.payload.last)
);

### tb/block_permutation_cipher_tb.sv
// Self-checking testbench for the block permutation cipher: directed cases and random streams.
`timescale 1ns / 100ps

module block_permutation_cipher_tb;
  import bpc_pkg::*;

  localparam int MAX_BLOCK   = 16;
  localparam int SETTLE_CYC  = 2 * MAX_BLOCK + 8;
  localparam int PHASE_ITEMS = 70;

  logic clk = 1'b0;
  logic rst_n;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  bpc_stream_if #(.payload_t(in_item_t))  in_ch ();
  bpc_stream_if #(.payload_t(out_item_t)) out_ch ();

  block_permutation_cipher #(.MAX_BLOCK(MAX_BLOCK)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cipher state mirrored by the testbench
  logic [7:0]  chr_buf [MAX_BLOCK];
  logic [4:0]  chr_count;
  logic [4:0]  len_reg;
  logic [63:0] key_reg;
  logic        decipher_reg;
  out_item_t   cipher_out_q [$];

  int  err_cnt;
  int  items_sent;
  int  chars_checked;
  int  groups_checked;
  int  reg_writes;
  bit  no_idle;
  int  rx_hold_req;

  function automatic int block_len();
    int n;
    n = len_reg;
    if (n == 0) n = 1;
    if (n > MAX_BLOCK) n = MAX_BLOCK;
    return n;
  endfunction

  function automatic void emit_block();
    int n;
    int src;
    out_item_t o;
    n = block_len();
    for (int i = 0; i < n; i++) begin
      src = 0;
      if (!decipher_reg) begin
        src = key_reg[4*i +: 4];
        if (src >= n) src = 0;
      end else begin
        for (int j = n - 1; j >= 0; j--) begin
          if (key_reg[4*j +: 4] == i) src = j;
        end
      end
      o.out_byte = chr_buf[src];
      o.last     = (i == n - 1);
      cipher_out_q.push_back(o);
    end
    chr_count = '0;
  endfunction

  function automatic void advance_cipher(input in_item_t it);
    int n;
    int pos;
    out_item_t o;
    n = block_len();
    if (it.flush) begin
      if (chr_count != 0) begin
        for (int p = chr_count; p < n; p++) chr_buf[p] = {1'b0, it.fill_char};
        emit_block();
      end
    end else if (it.data_byte >= 8'd32 && it.data_byte <= 8'd126) begin
      pos = chr_count;
      if (pos >= n) pos = n - 1;
      chr_buf[pos] = it.data_byte;
      chr_count = 5'(pos + 1);
      if (chr_count >= n) emit_block();
    end else begin
      o.out_byte = it.data_byte;
      o.last     = 1'b1;
      cipher_out_q.push_back(o);
    end
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold;
    int wait_cyc;
    hold = 0;
    wait_cyc = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req != 0) begin
        hold = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (wait_cyc > 0) begin
        wait_cyc--;
        out_ch.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        wait_cyc = gap_len();
        out_ch.ready <= (wait_cyc == 0);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_output
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (cipher_out_q.size() == 0) begin
        $display("%0t: unexpected transfer, out_byte %h last %b", $time,
                 out_ch.payload.out_byte, out_ch.payload.last);
        err_cnt++;
      end else begin
        want = cipher_out_q.pop_front();
        chars_checked++;
        if (want.last) groups_checked++;
        if (out_ch.payload.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %h actual %h", $time,
                   want.out_byte, out_ch.payload.out_byte);
          err_cnt++;
        end
        if (out_ch.payload.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time,
                   want.last, out_ch.payload.last);
          err_cnt++;
        end
      end
    end
  end

  task automatic send_item(input in_item_t it);
    int gap;
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    advance_cipher(it);
    items_sent++;
    @(negedge clk);
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_char(input logic [7:0] b);
    send_item('{data_byte: b, flush: 1'b0, fill_char: 7'($urandom_range(0, 127))});
  endtask

  task automatic send_flush(input logic [6:0] fc);
    send_item('{data_byte: 8'($urandom_range(0, 255)), flush: 1'b1, fill_char: fc});
  endtask

  task automatic send_random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send_flush(r < 6 ? 7'($urandom_range(32, 126)) : 7'($urandom_range(0, 127)));
    end else if (r < 18) begin
      send_char(r < 13 ? 8'($urandom_range(0, 31)) : 8'($urandom_range(127, 255)));
    end else begin
      send_char(8'($urandom_range(32, 126)));
    end
  endtask

  // Drop valid, wait for every predicted character, then let the block settle
  task automatic wait_cipher_idle();
    in_ch.valid <= 1'b0;
    while (cipher_out_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_BLOCK_LENGTH:  len_reg      = val[4:0];
      CFG_KEY_MAP:       key_reg      = val;
      CFG_DECIPHER_MODE: decipher_reg = val[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [63:0] shuffled_key(input int n);
    logic [3:0]  ent [16];
    logic [3:0]  t;
    logic [63:0] k;
    int          s;
    for (int i = 0; i < 16; i++) ent[i] = (i < n) ? 4'(i) : 4'($urandom_range(0, 15));
    for (int i = n - 1; i > 0; i--) begin
      s = $urandom_range(0, i);
      t = ent[i];
      ent[i] = ent[s];
      ent[s] = t;
    end
    for (int i = 0; i < 16; i++) k[4*i +: 4] = ent[i];
    return k;
  endfunction

  task automatic randomise_config();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 5)       n = 0;
    else if (r < 12) n = $urandom_range(17, 31);
    else             n = $urandom_range(1, 16);
    write_reg(CFG_BLOCK_LENGTH, 64'(n));
    r = $urandom_range(0, 99);
    if (r < 5)       write_reg(CFG_KEY_MAP, '0);
    else if (r < 10) write_reg(CFG_KEY_MAP, '1);
    else if (r < 75) write_reg(CFG_KEY_MAP, shuffled_key(n < 1 ? 1 : (n > 16 ? 16 : n)));
    else             write_reg(CFG_KEY_MAP, {$urandom, $urandom});
    write_reg(CFG_DECIPHER_MODE, {$urandom, $urandom});
  endtask

  task automatic test_pass_through_and_flush();
    send_flush(7'h41);
    send_char(8'h00);
    send_char(8'h1F);
    send_char(8'h7F);
    send_char(8'hFF);
    send_char(8'h20);
    send_char(8'h7E);
    send_flush(7'h00);
    wait_cipher_idle();
  endtask

  task automatic test_encipher_key();
    write_reg(CFG_BLOCK_LENGTH, 64'd4);
    write_reg(CFG_KEY_MAP, 64'hFEDC_BA98_7654_9022);
    write_reg(CFG_DECIPHER_MODE, 64'd0);
    send_char("a");
    send_char("b");
    send_char("c");
    send_char("d");
    wait_cipher_idle();
  endtask

  task automatic test_decipher_key();
    write_reg(CFG_DECIPHER_MODE, 64'd1);
    send_char("W");
    send_char("x");
    send_char("Y");
    send_char("z");
    wait_cipher_idle();
  endtask

  task automatic test_length_shrink();
    send_char("1");
    send_char("2");
    send_char("3");
    wait_cipher_idle();
    write_reg(CFG_BLOCK_LENGTH, 64'd2);
    send_char("4");
    wait_cipher_idle();
    write_reg(CFG_BLOCK_LENGTH, 64'd4);
    send_char("5");
    send_char("6");
    send_char("7");
    wait_cipher_idle();
    write_reg(CFG_BLOCK_LENGTH, 64'd2);
    send_flush(7'h2E);
    wait_cipher_idle();
  endtask

  task automatic test_length_limits();
    write_reg(CFG_DECIPHER_MODE, 64'd0);
    write_reg(CFG_BLOCK_LENGTH, 64'd0);
    send_char("q");
    wait_cipher_idle();
    write_reg(CFG_BLOCK_LENGTH, 64'd31);
    write_reg(CFG_KEY_MAP, 64'h0123_4567_89AB_CDEF);
    send_char("r");
    send_flush(7'h7F);
    wait_cipher_idle();
  endtask

  task automatic test_random_stream();
    for (int ph = 0; ph < 6; ph++) begin
      randomise_config();
      no_idle = (ph == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) send_random_item();
      wait_cipher_idle();
      no_idle = 1'b0;
    end
  endtask

  task automatic test_output_backpressure();
    write_reg(CFG_BLOCK_LENGTH, 64'd4);
    write_reg(CFG_KEY_MAP, shuffled_key(4));
    rx_hold_req = 300;
    for (int k = 0; k < 40; k++) send_char(8'($urandom_range(32, 126)));
    wait_cipher_idle();
  endtask

  initial begin
    #(20_000_000);
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    err_cnt       = 0;
    items_sent    = 0;
    chars_checked = 0;
    groups_checked = 0;
    reg_writes    = 0;
    no_idle       = 1'b0;
    rx_hold_req   = 0;
    chr_count     = '0;
    len_reg       = BLOCK_LENGTH_RST;
    key_reg       = KEY_MAP_RST;
    decipher_reg  = 1'b0;
    for (int i = 0; i < MAX_BLOCK; i++) chr_buf[i] = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_pass_through_and_flush();
    test_encipher_key();
    test_decipher_key();
    test_length_shrink();
    test_length_limits();
    test_random_stream();
    test_output_backpressure();

    if (cipher_out_q.size() != 0) begin
      $display("%0t: %0d predicted characters never transferred", $time,
               cipher_out_q.size());
      err_cnt++;
    end
    $display("Run covered %0d input transfers and %0d output characters in %0d groups,",
             items_sent, chars_checked, groups_checked);
    $display("over %0d register writes in encipher and decipher mode.", reg_writes);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
